[rtl/btnrep_pkg.sv]
package btnrep_pkg;

   localparam int BUTTON_BITS   = 16;
   localparam int WINDOW_FRAMES = 30;
   localparam int SAMPLE_PERIOD = 6;

   localparam int COUNT_BITS  = 8;
   localparam int SEL_BITS    = $clog2(BUTTON_BITS);
   localparam int SLOT_BITS   = $clog2(WINDOW_FRAMES);
   localparam int SUM_BITS    = $clog2(WINDOW_FRAMES + 1);
   localparam int PHASE_BITS  = (SAMPLE_PERIOD > 1) ? $clog2(SAMPLE_PERIOD) : 1;
   localparam int RATE_BITS   = 7;
   localparam int ADDR_BITS   = 5;
   localparam int DATA_BITS   = 32;
   localparam int RSP_BITS    = 80;

   localparam logic [COUNT_BITS-1:0]  RESET_INTERVAL = 8'd4;
   localparam logic [COUNT_BITS-1:0]  RESET_DELAY    = 8'd5;
   localparam logic [BUTTON_BITS-1:0] RESET_TRACKED  = 16'hFFFF;
   localparam logic [SEL_BITS-1:0]    RESET_FIRST    = 4'd8;
   localparam logic [SEL_BITS-1:0]    RESET_SECOND   = 4'd9;
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX      = 8'hFF;

   typedef enum logic [2:0] {
      REG_REPEAT_INTERVAL = 3'd0,
      REG_HOLD_DELAY      = 3'd1,
      REG_TRACKED_MASK    = 3'd2,
      REG_FIRST_RATE_BIT  = 3'd3,
      REG_SECOND_RATE_BIT = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]  repeat_interval;
      logic [COUNT_BITS-1:0]  hold_delay;
      logic [BUTTON_BITS-1:0] tracked_mask;
      logic [SEL_BITS-1:0]    first_rate_bit;
      logic [SEL_BITS-1:0]    second_rate_bit;
   } cfg_type;

endpackage

[rtl/button_autorepeat_press_rate_core.sv]
// A result is offered once its input has passed the input register, then the result
// register. Throughput: one item per cycle while rsp_tready does not stall the result; the
// per-button counters and the window sums update together as an item advances, so items
// follow back to back, and the result register frees as it is taken. Reset is synchronous
// and active high: counters, windows, sums, the previous button word, the valid flags and
// the configuration registers return to their reset values; no clearing pass is needed.
module button_autorepeat_press_rate_core
   import btnrep_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [BUTTON_BITS-1:0] req_tdata,   // [15:0] raw_buttons
   input  logic                   req_tuser,   // [0] menu_open
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [15:0] held_mask, [31:16] trigger_mask, [47:32] repeat_mask,
   // [54:48] first_rate_count, [61:55] second_rate_count, [77:62] passed_buttons
   output logic [RSP_BITS-1:0]    rsp_tdata,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [ADDR_BITS-1:0]   csr_paddr,
   input  logic [DATA_BITS-1:0]   csr_pwdata,
   output logic [DATA_BITS-1:0]   csr_prdata,
   output logic                   csr_pready
);

   cfg_type                cfg;
   logic                   in_valid_ff;
   logic [BUTTON_BITS-1:0] in_raw_ff;
   logic                   in_menu_ff;
   logic                   out_valid_ff;
   logic [RSP_BITS-1:0]    out_data_ff;
   logic [RSP_BITS-1:0]    out_data_in;
   logic                   out_free;
   logic                   advance;
   logic [BUTTON_BITS-1:0] rise, repeat_bits;
   logic [SUM_BITS-1:0]    first_count, second_count;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   btnrep_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   btnrep_typematic u_typematic (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .raw         (in_raw_ff),
      .cfg         (cfg),
      .rise        (rise),
      .repeat_bits (repeat_bits)
   );

   btnrep_rate u_rate (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .rise         (rise),
      .menu_open    (in_menu_ff),
      .cfg          (cfg),
      .first_count  (first_count),
      .second_count (second_count)
   );

   always_comb begin
      out_data_in = '0;
      out_data_in[15:0]  = in_raw_ff & cfg.tracked_mask;
      out_data_in[31:16] = rise & cfg.tracked_mask;
      out_data_in[47:32] = repeat_bits & cfg.tracked_mask;
      out_data_in[54:48] = RATE_BITS'(first_count);
      out_data_in[61:55] = RATE_BITS'(second_count);
      out_data_in[77:62] = in_menu_ff ? '0 : in_raw_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_raw_ff  <= req_tdata;
         in_menu_ff <= req_tuser;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   a_trigger_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[31:16] & ~rsp_tdata[15:0]) == '0))
      else $error("trigger mask has a button that is not held");

   a_trigger_repeats: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[31:16] & ~rsp_tdata[47:32]) == '0))
      else $error("press frame did not give a repeat pulse");

   a_repeat_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[47:32] & ~rsp_tdata[15:0]) == '0))
      else $error("repeat pulse on a button that is not held");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[54:48] <= RATE_BITS'(WINDOW_FRAMES)) &&
                      (rsp_tdata[61:55] <= RATE_BITS'(WINDOW_FRAMES))))
      else $error("press count exceeds the window length");

endmodule

[rtl/btnrep_csr.sv]
module btnrep_csr
   import btnrep_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_BITS-1:0] csr_paddr,
   input  logic [DATA_BITS-1:0] csr_pwdata,
   output logic [DATA_BITS-1:0] csr_prdata,
   output logic                 csr_pready,
   output cfg_type              cfg
);

   cfg_type       cfg_ff;
   reg_index_type index;
   logic          write_en;

   assign index      = reg_index_type'(csr_paddr[ADDR_BITS-1:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.repeat_interval <= RESET_INTERVAL;
         cfg_ff.hold_delay      <= RESET_DELAY;
         cfg_ff.tracked_mask    <= RESET_TRACKED;
         cfg_ff.first_rate_bit  <= RESET_FIRST;
         cfg_ff.second_rate_bit <= RESET_SECOND;
      end else if (write_en) begin
         case (index)
            REG_REPEAT_INTERVAL: cfg_ff.repeat_interval <= csr_pwdata[COUNT_BITS-1:0];
            REG_HOLD_DELAY:      cfg_ff.hold_delay      <= csr_pwdata[COUNT_BITS-1:0];
            REG_TRACKED_MASK:    cfg_ff.tracked_mask    <= csr_pwdata[BUTTON_BITS-1:0];
            REG_FIRST_RATE_BIT:  cfg_ff.first_rate_bit  <= csr_pwdata[SEL_BITS-1:0];
            REG_SECOND_RATE_BIT: cfg_ff.second_rate_bit <= csr_pwdata[SEL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (index)
         REG_REPEAT_INTERVAL: csr_prdata = DATA_BITS'(cfg_ff.repeat_interval);
         REG_HOLD_DELAY:      csr_prdata = DATA_BITS'(cfg_ff.hold_delay);
         REG_TRACKED_MASK:    csr_prdata = DATA_BITS'(cfg_ff.tracked_mask);
         REG_FIRST_RATE_BIT:  csr_prdata = DATA_BITS'(cfg_ff.first_rate_bit);
         REG_SECOND_RATE_BIT: csr_prdata = DATA_BITS'(cfg_ff.second_rate_bit);
         default:             csr_prdata = '0;
      endcase
   end

endmodule

[rtl/btnrep_typematic.sv]
module btnrep_typematic
   import btnrep_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic [BUTTON_BITS-1:0] raw,
   input  cfg_type                cfg,
   output logic [BUTTON_BITS-1:0] rise,
   output logic [BUTTON_BITS-1:0] repeat_bits
);

   logic [BUTTON_BITS-1:0] prev_ff;
   logic [COUNT_BITS-1:0]  held_ff  [BUTTON_BITS];
   logic [COUNT_BITS-1:0]  phase_ff [BUTTON_BITS];
   logic [COUNT_BITS-1:0]  held_in  [BUTTON_BITS];
   logic [COUNT_BITS-1:0]  phase_in [BUTTON_BITS];
   logic [COUNT_BITS-1:0]  interval;

   assign rise     = raw & ~prev_ff;
   // A zero interval behaves as one: a pulse on every frame past the delay.
   assign interval = (cfg.repeat_interval == '0) ? COUNT_BITS'(1) : cfg.repeat_interval;

   always_comb begin
      for (int i = 0; i < BUTTON_BITS; i++) begin
         if (rise[i]) begin
            held_in[i]  = '0;
            phase_in[i] = '0;
         end else begin
            held_in[i]  = (held_ff[i] == COUNT_MAX) ? COUNT_MAX : held_ff[i] + 1'b1;
            phase_in[i] = (({1'b0, phase_ff[i]} + 1'b1) >= {1'b0, interval}) ?
                          '0 : phase_ff[i] + 1'b1;
         end
         repeat_bits[i] = raw[i] && ((held_in[i] == '0) ||
                          ((held_in[i] > cfg.hold_delay) && (phase_in[i] == '0)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         for (int i = 0; i < BUTTON_BITS; i++) begin
            held_ff[i]  <= '0;
            phase_ff[i] <= '0;
         end
      end else if (advance) begin
         prev_ff <= raw;
         for (int i = 0; i < BUTTON_BITS; i++) begin
            held_ff[i]  <= held_in[i];
            phase_ff[i] <= phase_in[i];
         end
      end
   end

endmodule

[rtl/btnrep_rate.sv]
module btnrep_rate
   import btnrep_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic [BUTTON_BITS-1:0] rise,
   input  logic                   menu_open,
   input  cfg_type                cfg,
   output logic [SUM_BITS-1:0]    first_count,
   output logic [SUM_BITS-1:0]    second_count
);

   logic [WINDOW_FRAMES-1:0] first_win_ff, second_win_ff;
   logic [SUM_BITS-1:0]      first_sum_ff, second_sum_ff;
   logic [SUM_BITS-1:0]      first_pub_ff, second_pub_ff;
   logic [SLOT_BITS-1:0]     slot_ff;
   logic [PHASE_BITS-1:0]    phase_ff;
   logic [SUM_BITS-1:0]      first_sum_in, second_sum_in;
   logic                     first_mark, second_mark;
   logic                     publish;

   assign first_mark  = !menu_open && rise[cfg.first_rate_bit];
   assign second_mark = !menu_open && rise[cfg.second_rate_bit];
   assign publish     = (phase_ff == '0);

   // The slot being overwritten leaves the sum as the new mark enters it.
   assign first_sum_in  = first_sum_ff - SUM_BITS'(first_win_ff[slot_ff])
                          + SUM_BITS'(first_mark);
   assign second_sum_in = second_sum_ff - SUM_BITS'(second_win_ff[slot_ff])
                          + SUM_BITS'(second_mark);

   // The published sum is taken before this frame's slot is written.
   assign first_count  = publish ? first_sum_ff  : first_pub_ff;
   assign second_count = publish ? second_sum_ff : second_pub_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_win_ff  <= '0;
         second_win_ff <= '0;
         first_sum_ff  <= '0;
         second_sum_ff <= '0;
         first_pub_ff  <= '0;
         second_pub_ff <= '0;
         slot_ff       <= '0;
         phase_ff      <= '0;
      end else if (advance) begin
         first_win_ff[slot_ff]  <= first_mark;
         second_win_ff[slot_ff] <= second_mark;
         first_sum_ff  <= first_sum_in;
         second_sum_ff <= second_sum_in;
         first_pub_ff  <= first_count;
         second_pub_ff <= second_count;
         slot_ff  <= (slot_ff == SLOT_BITS'(WINDOW_FRAMES - 1)) ? '0 : slot_ff + 1'b1;
         phase_ff <= (phase_ff == PHASE_BITS'(SAMPLE_PERIOD - 1)) ? '0 : phase_ff + 1'b1;
      end
   end

endmodule
